// ===== rtl/core/plj_pkg.sv =====
// Shared types and codes for the preemptive LIFO job scheduler.
`default_nettype none
package plj_pkg;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned SIZE_W = 32;
  localparam int unsigned ID_W   = 8;

  // Error codes reported with every result
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  typedef struct packed {
    logic              func;
    logic [ID_W-1:0]   job_id;
    logic [SIZE_W-1:0] job_size;
    logic [TIME_W-1:0] current_time;
  } in_item_t;

  typedef struct packed {
    logic              cancel_completion;
    logic              schedule_valid;
    logic [TIME_W-1:0] completion_time;
    logic              done_valid;
    logic [ID_W-1:0]   done_job_id;
    logic [1:0]        error_code;
  } out_item_t;

  typedef enum logic {
    OP_ARRIVE   = 1'b0,
    OP_COMPLETE = 1'b1
  } op_e;

  // Classified item as held in the queue between front and back
  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   job_id;
    logic [SIZE_W-1:0] job_size;
    logic [TIME_W-1:0] now;
  } job_cmd_t;

  typedef struct packed {
    logic     valid;
    job_cmd_t cmd;
  } queue_head_t;

  // One stack entry below the running job
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] remaining;
  } stack_entry_t;

  typedef enum logic {
    BK_IDLE,
    BK_FETCH
  } back_state_e;

endpackage
`default_nettype wire

// ===== rtl/core/preemptive_lifo_job_scheduler_top.sv =====
// Top level of the preemptive last-come-first-served job scheduler.
// Arrivals and completions enter a two-entry queue and are executed one at a
// time by the back end, which keeps the running job in registers and the jobs
// it preempted in a stack RAM of STACK_DEPTH entries. An arrival, a rejected
// event, and a completion that leaves the stack empty are finished in the IDLE
// state of the back end; a completion that resumes an older job also passes
// through the FETCH state, set by the registered read of the stack RAM. Each
// item is registered in the queue before the back end takes it, and its result
// is registered at the output. The RAM needs no clearing after reset.
`default_nettype none
module preemptive_lifo_job_scheduler_top #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire plj_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output plj_pkg::out_item_t      out_data_o
);
  import plj_pkg::*;

  queue_head_t head;
  logic        pop;

  plj_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .head_o    (head),
    .pop_i     (pop)
  );

  plj_back #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Only a present item is removed from the queue
  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head.valid)
    else $error("queue popped while empty");

  // An error result carries nothing else
  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.error_code != ERR_OK |->
      !out_data_o.schedule_valid && !out_data_o.done_valid &&
      !out_data_o.cancel_completion)
    else $error("error result with side effects");

  // A cancel always comes with a new schedule
  a_cancel_sched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.cancel_completion |-> out_data_o.schedule_valid)
    else $error("cancel without schedule");

  // No result is both a preemption and a completion
  a_done_no_cancel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_valid |-> !out_data_o.cancel_completion)
    else $error("completion marked as preemption");

endmodule
`default_nettype wire

// ===== rtl/core/plj_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module plj_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/core/plj_front.sv =====
// Front end: accepts items, classifies them and holds them in a two-entry queue.
`default_nettype none
module plj_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire plj_pkg::in_item_t in_data_i,
  output plj_pkg::queue_head_t   head_o,
  input  wire logic              pop_i
);
  import plj_pkg::*;

  job_cmd_t   slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push;
  job_cmd_t   cmd;

  // Classify the incoming item
  always_comb begin
    cmd.op     = in_data_i.func ? OP_COMPLETE : OP_ARRIVE;
    cmd.job_id = in_data_i.job_id;
    cmd.job_size = in_data_i.job_size;
    cmd.now    = in_data_i.current_time;
  end

  assign in_stall_o = (fill_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    fill_d   = fill_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the item
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd;
    end
  end

  assign head_o.valid = (fill_q != 2'd0);
  assign head_o.cmd   = slot_q[rd_ptr_q];

endmodule
`default_nettype wire

// ===== rtl/core/plj_back.sv =====
// Back end: runs the job stack and drives the registered result.
`default_nettype none
module plj_back #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire plj_pkg::queue_head_t head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output plj_pkg::out_item_t        out_data_o
);
  import plj_pkg::*;

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  back_state_e       state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [TIME_W-1:0] run_start_q, run_start_d;
  logic [ID_W-1:0]   top_id_q, top_id_d;
  logic [SIZE_W-1:0] top_rem_q, top_rem_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  stack_entry_t      ram_wdata, ram_rdata;

  logic              out_free, full, empty;
  logic [CW-1:0]     count_m1, count_m2;
  logic [TIME_W-1:0] elapsed;
  logic [SIZE_W-1:0] new_rem;
  job_cmd_t          cmd;

  assign cmd      = head_i.cmd;
  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (count_q == CW'(STACK_DEPTH));
  assign empty    = (count_q == '0);
  assign count_m1 = count_q - CW'(1);
  assign count_m2 = count_q - CW'(2);

  // Charge the running job for the time it has run
  always_comb begin
    elapsed = (cmd.now >= run_start_q) ? (cmd.now - run_start_q) : '0;
    new_rem = (elapsed >= {{(TIME_W-SIZE_W){1'b0}}, top_rem_q}) ? '0
            : (top_rem_q - elapsed[SIZE_W-1:0]);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (head_i.valid && out_free && cmd.op == OP_COMPLETE &&
            count_q > CW'(1)) begin
          state_d = BK_FETCH;
        end
      end
      BK_FETCH: state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  // Datapath and result
  always_comb begin
    count_d     = count_q;
    run_start_d = run_start_q;
    top_id_d    = top_id_q;
    top_rem_d   = top_rem_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = count_m1[AW-1:0];
    ram_wdata   = '{id: top_id_q, remaining: new_rem};
    ram_raddr   = count_m2[AW-1:0];
    case (state_q)
      BK_IDLE: begin
        if (head_i.valid && out_free) begin
          out_d = '0;
          if (cmd.op == OP_ARRIVE) begin
            pop_o       = 1'b1;
            out_valid_d = 1'b1;
            if (full) begin
              out_d.error_code = ERR_FULL;
            end else begin
              // Push the preempted job below the new one
              ram_we                  = !empty;
              out_d.cancel_completion = !empty;
              out_d.schedule_valid    = 1'b1;
              out_d.completion_time   = cmd.now + {{(TIME_W-SIZE_W){1'b0}}, cmd.job_size};
              top_id_d    = cmd.job_id;
              top_rem_d   = cmd.job_size;
              count_d     = count_q + CW'(1);
              run_start_d = cmd.now;
            end
          end else if (empty) begin
            pop_o            = 1'b1;
            out_valid_d      = 1'b1;
            out_d.error_code = ERR_EMPTY;
          end else if (count_q == CW'(1)) begin
            pop_o             = 1'b1;
            out_valid_d       = 1'b1;
            out_d.done_valid  = 1'b1;
            out_d.done_job_id = top_id_q;
            count_d           = '0;
          end
          // Otherwise move to FETCH for the next job from the stack RAM
        end
      end
      BK_FETCH: begin
        // Resume the job that was below the finished one
        pop_o                 = 1'b1;
        out_valid_d           = 1'b1;
        out_d                 = '0;
        out_d.done_valid      = 1'b1;
        out_d.done_job_id     = top_id_q;
        out_d.schedule_valid  = 1'b1;
        out_d.completion_time = cmd.now + {{(TIME_W-SIZE_W){1'b0}}, ram_rdata.remaining};
        top_id_d              = ram_rdata.id;
        top_rem_d             = ram_rdata.remaining;
        count_d               = count_m1;
        run_start_d           = cmd.now;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      run_start_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      run_start_q <= run_start_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the running job and the result payload
  always_ff @(posedge clk_i) begin
    top_id_q  <= top_id_d;
    top_rem_q <= top_rem_d;
    out_q     <= out_d;
  end

  plj_ram #(
    .WIDTH($bits(stack_entry_t)),
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== bench/preemptive_lifo_job_scheduler_top_tb.sv =====
// Self-checking bench for the preemptive LIFO job scheduler with a scoreboard class.
module preemptive_lifo_job_scheduler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import plj_pkg::*;

  localparam int unsigned DEPTH = 16;

  // Predicts each scheduling result from its own copy of the job stack
  class sched_scoreboard;
    logic [ID_W-1:0]   ids [DEPTH];
    logic [SIZE_W-1:0] remaining [DEPTH];
    int unsigned       depth_used;
    logic [TIME_W-1:0] started_at;
    out_item_t         expected_q [$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       arrivals;
    int unsigned       completions;
    int unsigned       full_drops;
    int unsigned       empty_pops;
    int unsigned       peak_depth;

    function new();
      depth_used  = 0;
      started_at  = '0;
      mismatches  = 0;
      checked     = 0;
      arrivals    = 0;
      completions = 0;
      full_drops  = 0;
      empty_pops  = 0;
      peak_depth  = 0;
    endfunction

    // Work out the result of one accepted item and queue it
    function void note_input(in_item_t it);
      out_item_t         want;
      logic [TIME_W-1:0] elapsed;
      int unsigned       top;
      want = '0;
      if (op_e'(it.func) == OP_ARRIVE) begin
        arrivals++;
        if (depth_used >= DEPTH) begin
          want.error_code = ERR_FULL;
          full_drops++;
        end else begin
          // Charge the preempted job for the time it ran, floor at zero
          if (depth_used > 0) begin
            top = depth_used - 1;
            elapsed = (it.current_time >= started_at) ? it.current_time - started_at : '0;
            if (elapsed >= TIME_W'(remaining[top])) begin
              remaining[top] = '0;
            end else begin
              remaining[top] = remaining[top] - elapsed[SIZE_W-1:0];
            end
            want.cancel_completion = 1'b1;
          end
          ids[depth_used]       = it.job_id;
          remaining[depth_used] = it.job_size;
          depth_used++;
          if (depth_used > peak_depth) peak_depth = depth_used;
          want.schedule_valid  = 1'b1;
          want.completion_time = it.current_time + TIME_W'(it.job_size);
          started_at = it.current_time;
        end
      end else begin
        completions++;
        if (depth_used == 0) begin
          want.error_code = ERR_EMPTY;
          empty_pops++;
        end else begin
          // Pop the running job and resume the one below it
          depth_used--;
          want.done_valid  = 1'b1;
          want.done_job_id = ids[depth_used];
          if (depth_used > 0) begin
            want.schedule_valid  = 1'b1;
            want.completion_time = it.current_time + TIME_W'(remaining[depth_used - 1]);
            started_at = it.current_time;
          end
        end
      end
      expected_q.push_back(want);
    endfunction

    function void field_check(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        if (mismatches < 10) begin
          $display("mismatch in %s: expected %0h, got %0h", name, want, got);
        end
        mismatches++;
      end
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        if (mismatches < 10) $display("result with nothing expected: %0h", got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      field_check("cancel_completion", want.cancel_completion, got.cancel_completion);
      field_check("schedule_valid", want.schedule_valid, got.schedule_valid);
      field_check("completion_time", want.completion_time, got.completion_time);
      field_check("done_valid", want.done_valid, got.done_valid);
      field_check("done_job_id", want.done_job_id, got.done_job_id);
      field_check("error_code", want.error_code, got.error_code);
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      calm      = 1'b0;

  logic [TIME_W-1:0] now_t = '0;
  sched_scoreboard   sb = new();

  preemptive_lifo_job_scheduler_top #(
    .STACK_DEPTH(DEPTH)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  always #4 clk = ~clk;

  // Watch both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Stall the result side at random, except during the calm stretch
  initial begin
    forever begin
      @(negedge clk);
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 26);
    end
  end

  // Give up after a generous fixed time
  initial begin
    #5000000;
    $display("preemptive_lifo_job_scheduler_top_tb NOT OK");
    $finish;
  end

  function automatic in_item_t job(op_e op, logic [ID_W-1:0] id, logic [SIZE_W-1:0] size,
                                   logic [TIME_W-1:0] t);
    in_item_t it;
    it.func         = op;
    it.job_id       = id;
    it.job_size     = size;
    it.current_time = t;
    return it;
  endfunction

  // Build a random event; time mostly moves forward in small steps
  function in_item_t random_job(int unsigned arrive_pct);
    in_item_t    it;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) begin
      now_t = now_t + TIME_W'($urandom_range(40));
    end else if (r < 80) begin
      now_t = now_t - TIME_W'($urandom_range(100));
    end else if (r < 88) begin
      now_t = {16'($urandom), 32'($urandom)};
    end
    it.func   = ($urandom_range(99) < arrive_pct) ? OP_ARRIVE : OP_COMPLETE;
    it.job_id = 8'($urandom);
    r = $urandom_range(99);
    if (r < 60) begin
      it.job_size = SIZE_W'($urandom_range(60));
    end else if (r < 85) begin
      it.job_size = SIZE_W'($urandom_range(5000));
    end else begin
      it.job_size = 32'($urandom);
    end
    it.current_time = now_t;
    return it;
  endfunction

  // Offer one item, starting and ending at a falling edge
  task automatic send_item(in_item_t it);
    logic taken;
    if (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
      while (!calm && $urandom_range(99) < 26) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end
  endtask

  initial begin
    int unsigned arrive_pct;
    int unsigned waited;
    arrive_pct = 50;
    waited     = 0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty pop, size and time extremes, wrap, time going backwards
    send_item(job(OP_COMPLETE, 8'h00, 32'h0, 48'h0));
    send_item(job(OP_ARRIVE, 8'h00, 32'h0, 48'h0));
    send_item(job(OP_ARRIVE, 8'hFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
    send_item(job(OP_ARRIVE, 8'h5A, 32'd100, 48'd10));
    send_item(job(OP_ARRIVE, 8'hA5, 32'd50, 48'd30));
    // Elapsed time beyond the remaining time saturates
    send_item(job(OP_ARRIVE, 8'h01, 32'd5, 48'd1000));
    // Drain with resumes, the last pop leaves the stack empty
    send_item(job(OP_COMPLETE, 8'hFF, 32'hFFFF_FFFF, 48'd1002));
    send_item(job(OP_COMPLETE, 8'h00, 32'h0, 48'd1003));
    send_item(job(OP_COMPLETE, 8'h00, 32'h0, 48'hFFFF_FFFF_FFF0));
    send_item(job(OP_COMPLETE, 8'h00, 32'h0, 48'd1010));
    send_item(job(OP_COMPLETE, 8'h00, 32'h0, 48'd1011));
    // Fill the stack, then push once more onto the full stack
    for (int i = 0; i <= DEPTH; i++) begin
      send_item(job(OP_ARRIVE, 8'(i * 17), 32'(i * 7), 48'(2000 + i * 3)));
    end
    now_t = 48'd3000;

    // Random: segments that fill, hover and drain the stack
    for (int n = 0; n < 2000; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(4))
          0: arrive_pct = 90;
          1: arrive_pct = 70;
          2: arrive_pct = 50;
          3: arrive_pct = 30;
          default: arrive_pct = 10;
        endcase
      end
      calm = (n >= 300 && n < 700);
      // Hold off until every queued result has come out
      if (n == 1000) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.expected_q.size() != 0) @(negedge clk);
      end
      send_item(random_job(arrive_pct));
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (sb.expected_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.expected_q.size() != 0) begin
      $display("%0d expected results never came", sb.expected_q.size());
      sb.mismatches += sb.expected_q.size();
    end
    repeat (8) @(posedge clk);

    $display("covered %0d results: %0d arrivals, %0d completions, stack peak %0d",
             sb.checked, sb.arrivals, sb.completions, sb.peak_depth);
    $display("rejected: %0d pushes on a full stack, %0d pops on an empty one",
             sb.full_drops, sb.empty_pops);
    if (sb.mismatches == 0) begin
      $display("preemptive_lifo_job_scheduler_top_tb OK");
    end else begin
      $display("preemptive_lifo_job_scheduler_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/plj_pkg.sv
rtl/core/plj_ram.sv
rtl/core/plj_front.sv
rtl/core/plj_back.sv
rtl/core/preemptive_lifo_job_scheduler_top.sv
bench/preemptive_lifo_job_scheduler_top_tb.sv
